// File: hdl/svm_pkg.sv
// Package for the sample voice mixer: operation codes, gain limits, widths.
// No dependencies; imported by svm_mac, sample_voice_mixer, svm_checker and the testbench.
`default_nettype none
package svm_pkg;
    localparam int unsigned OP_W    = 3;
    localparam int unsigned GAIN_W  = 9;
    localparam int unsigned POS_W   = 34;
    localparam int unsigned STEP_W  = 18;
    localparam int unsigned ACC_W   = 32;
    localparam logic [GAIN_W-1:0] GAIN_MAX     = 9'd256;
    localparam logic [GAIN_W-1:0] EFFECT_RESET = 9'd230;
    localparam logic [GAIN_W-1:0] MUSIC_RESET  = 9'd128;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 3'd0,
        OP_START_FX = 3'd1,
        OP_START_MUSIC = 3'd2,
        OP_STOP_MUSIC = 3'd3,
        OP_PAUSE = 3'd4,
        OP_FRAME = 3'd5
    } op_t;

    localparam logic CFG_EFFECT = 1'b0;
    localparam logic CFG_MUSIC  = 1'b1;

    // Control from the sequencer to the shared multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic add_l;
        logic add_r;
    } mac_ctl_t;

    function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] v);
        clamp_gain = (v > GAIN_MAX) ? GAIN_MAX : v;
    endfunction
endpackage
`default_nettype wire

// File: hdl/sample_voice_mixer.sv
// Sample voice mixer top level: sample store, voice tables, sequencer.
// Depends on svm_pkg and svm_mac.
//
// One input word is taken at a time. Writes and control operations take effect
// as the word is accepted. A frame request walks voices 0..VOICES-1 then music
// through the single sample-store read port and one shared multiplier: an idle
// or finished slot only passes the check state, an active mono slot goes on
// through a read and an accumulate state, and an active stereo slot adds a
// second read and accumulate pair for the right sample; a done state then loads
// the result. The result word sits in an output register;
// other input words are accepted while it waits, but the next frame request
// is held off until the result word has been taken.
`default_nettype none
module sample_voice_mixer
    import svm_pkg::*;
#(
    parameter int VOICES = 8,
    parameter int SAMPLE_WORDS = 65536
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: operation[2:0], address[18:3], sample_value[34:19],
    // frame_count[50:35], is_stereo[51], rate_step[69:52], pause_flag[70]
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: left_sample[15:0], right_sample[31:16]
    output logic [31:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_wdata
);
    localparam int AW = $clog2(SAMPLE_WORDS);
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int NV = VOICES + 1; // music is the last slot
    localparam int SW = $clog2(NV + 1);

    typedef enum logic [2:0] {ST_IDLE, ST_CHECK, ST_READ_L, ST_READ_R,
                              ST_MAC_L, ST_MAC_R, ST_DONE} state_t;

    // Unpack input word.
    op_t              in_op;
    logic [15:0]      in_addr, in_val, in_len;
    logic             in_two, in_pause;
    logic [STEP_W-1:0] in_step;
    assign in_op    = op_t'(s_tdata[2:0]);
    assign in_addr  = s_tdata[18:3];
    assign in_val   = s_tdata[34:19];
    assign in_len   = s_tdata[50:35];
    assign in_two   = s_tdata[51];
    assign in_step  = s_tdata[69:52];
    assign in_pause = s_tdata[70];

    logic [GAIN_W-1:0] effect_vol_reg, music_gain_reg;
    logic [15:0] mem [SAMPLE_WORDS];
    logic signed [15:0] rd_reg;

    // Effect voice tables; on_reg bit VOICES marks the music slot.
    logic [NV-1:0]      on_reg;
    logic [15:0]        base_reg [VOICES];
    logic [15:0]        len_reg  [VOICES];
    logic [VOICES-1:0]  two_reg;
    logic [STEP_W-1:0]  step_reg [VOICES];
    logic [POS_W-1:0]   pos_reg  [VOICES];
    logic [GAIN_W-1:0]  gain_reg [VOICES];

    // Music slot.
    logic [15:0]        mu_base_reg, mu_len_reg;
    logic               mu_two_reg;
    logic [STEP_W-1:0]  mu_step_reg;
    logic [POS_W-1:0]   mu_pos_reg;
    logic               held_reg;

    state_t state_reg;
    logic [SW-1:0] slot_reg;
    logic [VW-1:0] slot_v;
    logic [17:0]   p_reg;
    logic          busy;
    logic          out_full_reg;
    logic [31:0]   out_reg;

    logic is_music;
    assign is_music = (slot_reg == SW'(VOICES));
    assign slot_v   = slot_reg[VW-1:0];

    // Free voice search: lowest off voice, else voice 0.
    logic [VW-1:0] free_v;
    always_comb
    begin
        free_v = '0;
        for (int i = VOICES - 1; i >= 0; i--)
            if (!on_reg[i])
                free_v = VW'(i);
    end

    assign busy     = (state_reg != ST_IDLE);
    assign s_tready = !busy && !(out_full_reg && in_op == OP_FRAME);
    logic acc;
    assign acc = s_tvalid && s_tready;

    // Current slot fields and read address.
    logic [15:0]       cur_base, cur_len;
    logic              cur_two;
    logic [STEP_W-1:0] cur_step;
    logic [POS_W-1:0]  cur_pos;
    logic [AW-1:0]     rd_addr;
    always_comb
    begin
        if (is_music)
        begin
            cur_base = mu_base_reg;
            cur_len  = mu_len_reg;
            cur_two  = mu_two_reg;
            cur_step = mu_step_reg;
            cur_pos  = mu_pos_reg;
        end
        else
        begin
            cur_base = base_reg[slot_v];
            cur_len  = len_reg[slot_v];
            cur_two  = two_reg[slot_v];
            cur_step = step_reg[slot_v];
            cur_pos  = pos_reg[slot_v];
        end
        if (cur_two)
            rd_addr = AW'(cur_base + {p_reg[14:0], 1'b0} + {15'd0, state_reg == ST_READ_R});
        else
            rd_addr = AW'(cur_base + p_reg[15:0]);
    end

    // Integer position at or past the length; music restarts from zero then.
    logic past_end;
    assign past_end = (cur_pos[POS_W-1:16] >= {2'd0, cur_len});

    // Advance the position after the last sample is read.
    logic             adv_pos;
    logic [POS_W-1:0] next_pos;
    assign adv_pos  = (state_reg == ST_MAC_L && !cur_two) || (state_reg == ST_MAC_R);
    assign next_pos = {p_reg, (is_music && past_end) ? 16'd0 : cur_pos[15:0]}
                      + {16'd0, cur_step};

    // Sample store: one write and one read per cycle.
    always_ff @(posedge clk)
    begin
        if (acc && in_op == OP_WRITE)
            mem[AW'(in_addr)] <= in_val;
        rd_reg <= mem[rd_addr];
    end

    mac_ctl_t ctl;
    logic [GAIN_W-1:0] cur_gain;
    logic signed [15:0] lq, rq;
    assign cur_gain = is_music ? music_gain_reg : gain_reg[slot_v];
    always_comb
    begin
        ctl.clear = acc && in_op == OP_FRAME;
        ctl.add_l = (state_reg == ST_MAC_L);
        ctl.add_r = (state_reg == ST_MAC_R) || (state_reg == ST_MAC_L && !cur_two);
    end

    svm_mac u_mac (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .sample(rd_reg),
        .gain(cur_gain), .left_q(lq), .right_q(rq)
    );

    assign m_tvalid = out_full_reg;
    assign m_tdata  = out_reg;

    // Configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            effect_vol_reg <= EFFECT_RESET;
            music_gain_reg <= MUSIC_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_EFFECT)
                effect_vol_reg <= clamp_gain(cfg_wdata);
            else
                music_gain_reg <= clamp_gain(cfg_wdata);
        end
    end

    // Effect voice payload tables (no reset needed).
    always_ff @(posedge clk)
    begin
        if (acc && in_op == OP_START_FX)
        begin
            base_reg[free_v] <= in_addr;
            len_reg[free_v]  <= in_len;
            two_reg[free_v]  <= in_two;
            step_reg[free_v] <= in_step;
            pos_reg[free_v]  <= '0;
            gain_reg[free_v] <= effect_vol_reg;
        end
        if (adv_pos && !is_music)
            pos_reg[slot_v] <= next_pos;
    end

    // Sequencer and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            slot_reg     <= '0;
            p_reg        <= '0;
            on_reg       <= '0;
            held_reg     <= 1'b0;
            out_full_reg <= 1'b0;
            out_reg      <= '0;
            mu_base_reg  <= '0;
            mu_len_reg   <= '0;
            mu_two_reg   <= 1'b0;
            mu_step_reg  <= '0;
            mu_pos_reg   <= '0;
        end
        else
        begin
            if (out_full_reg && m_tready)
                out_full_reg <= 1'b0;
            if (adv_pos && is_music)
                mu_pos_reg <= next_pos;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (acc)
                    begin
                        unique case (in_op)
                            OP_START_FX:    on_reg[free_v] <= 1'b1;
                            OP_START_MUSIC:
                            begin
                                on_reg[VOICES] <= 1'b1;
                                mu_base_reg    <= in_addr;
                                mu_len_reg     <= in_len;
                                mu_two_reg     <= in_two;
                                mu_step_reg    <= in_step;
                                mu_pos_reg     <= '0;
                                held_reg       <= 1'b0;
                            end
                            OP_STOP_MUSIC:  on_reg[VOICES] <= 1'b0;
                            OP_PAUSE:       held_reg <= in_pause;
                            OP_FRAME:
                            begin
                                slot_reg  <= '0;
                                state_reg <= ST_CHECK;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CHECK:
                begin
                    if (is_music)
                    begin
                        if (on_reg[VOICES] && !held_reg)
                        begin
                            p_reg <= past_end ? '0 : cur_pos[POS_W-1:16];
                            state_reg <= ST_READ_L;
                        end
                        else
                            state_reg <= ST_DONE;
                    end
                    else if (on_reg[slot_v] && past_end)
                    begin
                        on_reg[slot_v] <= 1'b0;
                        slot_reg <= slot_reg + 1'b1;
                    end
                    else if (on_reg[slot_v])
                    begin
                        p_reg <= cur_pos[POS_W-1:16];
                        state_reg <= ST_READ_L;
                    end
                    else
                        slot_reg <= slot_reg + 1'b1;
                end
                ST_READ_L: state_reg <= ST_MAC_L;
                ST_MAC_L:
                begin
                    if (cur_two)
                        state_reg <= ST_READ_R;
                    else if (is_music)
                        state_reg <= ST_DONE;
                    else
                    begin
                        slot_reg  <= slot_reg + 1'b1;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_READ_R: state_reg <= ST_MAC_R;
                ST_MAC_R:
                begin
                    if (is_music)
                        state_reg <= ST_DONE;
                    else
                    begin
                        slot_reg  <= slot_reg + 1'b1;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_DONE:
                begin
                    out_reg      <= {rq, lq};
                    out_full_reg <= 1'b1;
                    state_reg    <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_tready) else $error("accept while mixing");
    a_done_fills: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE |=> out_full_reg) else $error("frame lost");
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> slot_reg <= SW'(VOICES)) else $error("slot out of range");
`endif
endmodule
`default_nettype wire

// File: hdl/svm_mac.sv
// Shared multiply-accumulate unit: one 16x9 signed product per cycle into
// the left and/or right accumulator, plus floor-and-saturate to Q1.15.
// Depends on svm_pkg.
`default_nettype none
module svm_mac
    import svm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mac_ctl_t           ctl,
    input  wire logic signed [15:0] sample,
    input  wire logic [GAIN_W-1:0]  gain,
    output logic signed [15:0]      left_q,
    output logic signed [15:0]      right_q
);
    logic signed [ACC_W-1:0] acc_l_reg, acc_r_reg;
    logic signed [ACC_W-1:0] prod;

    assign prod = ACC_W'(sample) * ACC_W'($signed({1'b0, gain}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end
        else if (ctl.clear)
        begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end
        else
        begin
            if (ctl.add_l)
                acc_l_reg <= acc_l_reg + prod;
            if (ctl.add_r)
                acc_r_reg <= acc_r_reg + prod;
        end
    end

    // Arithmetic shift floors; then saturate.
    function automatic logic signed [15:0] sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-9:0] q;
        q = (ACC_W-8)'(a >>> 8);
        if (q > 32767)
            sat = 16'sh7FFF;
        else if (q < -32768)
            sat = 16'sh8000;
        else
            sat = q[15:0];
    endfunction

    assign left_q  = sat(acc_l_reg);
    assign right_q = sat(acc_r_reg);
endmodule
`default_nettype wire

// File: tb/svm_checker.sv
// Scoreboard for the sample voice mixer: follows the input and config channels,
// predicts each stereo frame and checks the output words in order.
// Depends on svm_pkg for the operation codes and register indexes.
`timescale 1ns / 1ps
module svm_checker
    import svm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [71:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_wdata,
    output int               outstanding,
    output int               errors,
    output int               frames_checked
);
    typedef struct packed {
        logic        pad;
        logic        pause_flag;
        logic [17:0] rate_step;
        logic        is_stereo;
        logic [15:0] frame_count;
        logic [15:0] sample_value;
        logic [15:0] address;
        logic [2:0]  operation;
    } cmd_t;

    typedef struct packed {
        logic [15:0] right_sample;
        logic [15:0] left_sample;
    } frame_t;

    localparam int NV = 8;

    logic [15:0] store [0:65535];
    logic        fx_on   [NV];
    logic [15:0] fx_base [NV];
    logic [15:0] fx_len  [NV];
    logic        fx_st   [NV];
    logic [17:0] fx_step [NV];
    logic [33:0] fx_pos  [NV];
    logic [8:0]  fx_gain [NV];
    logic        mu_on, mu_st, mu_held;
    logic [15:0] mu_base, mu_len;
    logic [17:0] mu_step;
    logic [33:0] mu_pos;
    logic [8:0]  fx_volume, mu_gain;
    frame_t      frame_q [$];

    function automatic logic [8:0] limit_gain(input logic [8:0] v);
        return (v > GAIN_MAX) ? GAIN_MAX : v;
    endfunction

    // Add one voice's sample pair, scaled by its gain, to the accumulators.
    function automatic void mix_voice(inout longint acc_l, inout longint acc_r,
                                      input logic [15:0] base, input logic st,
                                      input logic [17:0] p, input logic [8:0] g);
        logic [15:0] a;
        longint      l, r;
        a = st ? base + {p[14:0], 1'b0} : base + p[15:0];
        l = longint'($signed(store[a]));
        r = st ? longint'($signed(store[a + 16'd1])) : l;
        acc_l += l * longint'(g);
        acc_r += r * longint'(g);
    endfunction

    function automatic logic [15:0] to_q15(input longint acc);
        longint q;
        q = acc >>> 8;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic frame_t mix_frame();
        longint      acc_l, acc_r;
        logic [17:0] p;
        frame_t      f;
        acc_l = 0;
        acc_r = 0;
        for (int i = 0; i < NV; i++)
        begin
            if (fx_on[i])
            begin
                p = fx_pos[i][33:16];
                if (p >= fx_len[i])
                    fx_on[i] = 1'b0;
                else
                begin
                    mix_voice(acc_l, acc_r, fx_base[i], fx_st[i], p, fx_gain[i]);
                    fx_pos[i] = fx_pos[i] + fx_step[i];
                end
            end
        end
        if (mu_on && !mu_held)
        begin
            p = mu_pos[33:16];
            // Loop back to the start once the music runs past its length.
            if (p >= mu_len)
            begin
                mu_pos = '0;
                p = '0;
            end
            mix_voice(acc_l, acc_r, mu_base, mu_st, p, mu_gain);
            mu_pos = mu_pos + mu_step;
        end
        f.left_sample = to_q15(acc_l);
        f.right_sample = to_q15(acc_r);
        return f;
    endfunction

    function automatic void apply_cmd(input cmd_t c);
        int v;
        case (c.operation)
            OP_WRITE:
                store[c.address] = c.sample_value;
            OP_START_FX:
            begin
                // Take the lowest free voice; steal voice 0 when all are busy.
                v = 0;
                for (int i = NV - 1; i >= 0; i--)
                    if (!fx_on[i]) v = i;
                fx_on[v] = 1'b1;
                fx_base[v] = c.address;
                fx_len[v] = c.frame_count;
                fx_st[v] = c.is_stereo;
                fx_step[v] = c.rate_step;
                fx_pos[v] = '0;
                fx_gain[v] = fx_volume;
            end
            OP_START_MUSIC:
            begin
                mu_on = 1'b1;
                mu_base = c.address;
                mu_len = c.frame_count;
                mu_st = c.is_stereo;
                mu_step = c.rate_step;
                mu_pos = '0;
                mu_held = 1'b0;
            end
            OP_STOP_MUSIC:
                mu_on = 1'b0;
            OP_PAUSE:
                mu_held = c.pause_flag;
            OP_FRAME:
                frame_q.push_back(mix_frame());
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_t exp_f, got_f;
        if (!rst_n)
        begin
            for (int i = 0; i < NV; i++)
                fx_on[i] = 1'b0;
            mu_on = 1'b0;
            mu_st = 1'b0;
            mu_held = 1'b0;
            mu_base = '0;
            mu_len = '0;
            mu_step = '0;
            mu_pos = '0;
            fx_volume = EFFECT_RESET;
            mu_gain = MUSIC_RESET;
            frame_q.delete();
            errors = 0;
            frames_checked = 0;
        end
        else
        begin
            // Check the output first: a word accepted now cannot yield a frame yet.
            if (m_tvalid && m_tready)
            begin
                got_f = m_tdata;
                if (frame_q.size() == 0)
                begin
                    $error("unexpected frame word %h", m_tdata);
                    errors++;
                end
                else
                begin
                    exp_f = frame_q.pop_front();
                    frames_checked++;
                    if (got_f.left_sample !== exp_f.left_sample)
                    begin
                        $error("left_sample expected %h actual %h",
                               exp_f.left_sample, got_f.left_sample);
                        errors++;
                    end
                    if (got_f.right_sample !== exp_f.right_sample)
                    begin
                        $error("right_sample expected %h actual %h",
                               exp_f.right_sample, got_f.right_sample);
                        errors++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_EFFECT)
                    fx_volume = limit_gain(cfg_wdata);
                else
                    mu_gain = limit_gain(cfg_wdata);
            end
            if (s_tvalid && s_tready)
                apply_cmd(cmd_t'(s_tdata));
        end
        outstanding = frame_q.size();
    end
endmodule

// File: tb/testbench.sv
// Top of the mixer testbench: clock, reset, stimulus and verdict.
// Depends on svm_pkg, sample_voice_mixer and svm_checker.
`timescale 1ns / 1ps
module testbench;
    import svm_pkg::*;

    localparam int  RING = 256;        // written store words around address 0
    localparam int  RING_LO = 65536 - RING / 2;
    localparam int  SETTLE = 50;       // covers the slowest frame walk
    localparam int  LIMIT = 600000;
    localparam int  PHASES = 4;
    localparam int  PER_PHASE = 190;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // tdata: operation[2:0], address[18:3], sample_value[34:19],
    // frame_count[50:35], is_stereo[51], rate_step[69:52], pause_flag[70]
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // tdata: left_sample[15:0], right_sample[31:16]
    logic [31:0] m_tdata;
    logic        cfg_we;
    logic        cfg_index;
    logic [8:0]  cfg_wdata;
    int          outstanding, errors, frames_checked;
    int          cycles, words_sent, burst_left;
    int          stall_mode, stall_left;

    sample_voice_mixer uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    svm_checker scoreboard (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .outstanding(outstanding), .errors(errors), .frames_checked(frames_checked)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: alternate between always-ready, coin-flip and long-stall stretches.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(5, 60);
        end
        stall_left--;
        case (stall_mode)
            0: m_tready = 1'b1;
            1: m_tready = $urandom_range(0, 1);
            default: m_tready = ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic logic [71:0] pack_word(input op_t op, input logic [15:0] addr,
                                              input logic [15:0] value,
                                              input logic [15:0] len, input logic st,
                                              input logic [17:0] step, input logic pause);
        return {1'b0, pause, step, st, len, value, addr, op};
    endfunction

    // Drive one word at the falling edge and hold it until the handshake.
    task automatic push_word(input logic [71:0] w);
        if (burst_left == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 30);
        end
        s_tdata = w;
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        s_tvalid = 1'b0;
        burst_left--;
        words_sent++;
    endtask

    // Wait for every frame to drain, then let a trailing frame walk finish.
    task automatic drain();
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [8:0] value);
        cfg_index = idx;
        cfg_wdata = value;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Start address inside the written ring; off counts from the ring's low end.
    function automatic logic [15:0] ring_addr(input int off);
        return 16'(RING_LO + off);
    endfunction

    task automatic random_sound(input op_t op);
        int          off, span;
        logic        st;
        logic [15:0] len;
        logic [17:0] step;
        st = $urandom_range(0, 1);
        off = $urandom_range(0, RING - 2);
        span = (RING - off) / (st ? 2 : 1);
        step = ($urandom_range(0, 3) == 0) ? 18'($urandom) : 18'($urandom_range(0, 'h20000));
        len = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, span));
        // Music held at position 0 may carry any length.
        if (op == OP_START_MUSIC && $urandom_range(0, 4) == 0)
        begin
            step = '0;
            len = 16'($urandom);
        end
        push_word(pack_word(op, ring_addr(off), 16'($urandom), len, st, step,
                            1'($urandom)));
    endtask

    task automatic random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 14)
            push_word(pack_word(OP_WRITE, ring_addr($urandom_range(0, RING - 1)),
                                16'($urandom), 16'($urandom), 1'($urandom),
                                18'($urandom), 1'($urandom)));
        else if (pick < 18)
            push_word(pack_word(OP_WRITE, 16'($urandom), 16'($urandom), 16'($urandom),
                                1'($urandom), 18'($urandom), 1'($urandom)));
        else if (pick < 32)
            random_sound(OP_START_FX);
        else if (pick < 37)
            random_sound(OP_START_MUSIC);
        else if (pick < 40)
            push_word(pack_word(OP_STOP_MUSIC, 16'($urandom), 16'($urandom),
                                16'($urandom), 1'($urandom), 18'($urandom), 1'($urandom)));
        else if (pick < 45)
            push_word(pack_word(OP_PAUSE, 16'($urandom), 16'($urandom), 16'($urandom),
                                1'($urandom), 18'($urandom), 1'($urandom)));
        else if (pick < 47)
            push_word({1'b0, 68'($urandom) << 3, 3'($urandom_range(6, 7))});
        else
            push_word(pack_word(OP_FRAME, 16'($urandom), 16'($urandom), 16'($urandom),
                                1'($urandom), 18'($urandom), 1'($urandom)));
    endtask

    initial
    begin
        logic [8:0] fx_set [PHASES];
        logic [8:0] mu_set [PHASES];
        cycles = 0;
        words_sent = 0;
        burst_left = 0;
        stall_mode = 0;
        stall_left = 0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_EFFECT;
        cfg_wdata = '0;
        rst_n = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Fill the ring so that no sound ever reads an unwritten word.
        for (int i = 0; i < RING; i++)
            push_word(pack_word(OP_WRITE, ring_addr(i), 16'($urandom), 16'($urandom),
                                1'($urandom), 18'($urandom), 1'($urandom)));
        // Full-scale words at addresses 0, 1 and 65535, in the middle of the ring.
        push_word(pack_word(OP_WRITE, 16'd0, 16'h7FFF, '0, 1'b0, '0, 1'b0));
        push_word(pack_word(OP_WRITE, 16'd1, 16'h7FFF, '0, 1'b0, '0, 1'b0));
        push_word(pack_word(OP_WRITE, 16'd65535, 16'h8000, '1, 1'b1, '1, 1'b1));
        drain();
        write_reg(CFG_EFFECT, 9'd256);
        write_reg(CFG_MUSIC, 9'd256);

        // All voices busy on loud words, then a ninth start steals voice 0.
        for (int i = 0; i < 9; i++)
            push_word(pack_word(OP_START_FX, 16'd0, '0, 16'd2, 1'b0, 18'h10000, 1'b0));
        push_word(pack_word(OP_START_MUSIC, 16'd65535, '0, 16'd1, 1'b0, 18'h3FFFF, 1'b0));
        repeat (3) push_word(pack_word(OP_FRAME, '0, '0, '0, 1'b0, '0, 1'b0));
        push_word(pack_word(OP_PAUSE, '0, '0, '0, 1'b0, '0, 1'b1));
        push_word(pack_word(OP_FRAME, '0, '0, '0, 1'b0, '0, 1'b0));
        push_word(pack_word(OP_PAUSE, '0, '0, '0, 1'b0, '0, 1'b0));
        push_word(pack_word(OP_FRAME, '0, '0, '0, 1'b0, '0, 1'b0));
        push_word(pack_word(OP_STOP_MUSIC, '0, '0, '0, 1'b0, '0, 1'b0));
        push_word(pack_word(OP_FRAME, '0, '0, '0, 1'b0, '0, 1'b0));
        // Unused codes do nothing.
        push_word({69'h1F_FFFF_FFFF_FFFF_FFFF, 3'd6});
        push_word({69'h0, 3'd7});
        // Zero-length stereo music reading the top two words of the store.
        push_word(pack_word(OP_START_MUSIC, 16'd65534, '0, 16'd0, 1'b1, 18'h3FFFF, 1'b0));
        repeat (2) push_word(pack_word(OP_FRAME, '0, '0, '0, 1'b0, '0, 1'b0));
        push_word(pack_word(OP_START_MUSIC, 16'd65535, '0, 16'hFFFF, 1'b0, '0, 1'b0));
        push_word(pack_word(OP_FRAME, '0, '0, '0, 1'b0, '0, 1'b0));
        push_word(pack_word(OP_STOP_MUSIC, '0, '0, '0, 1'b0, '0, 1'b0));

        // Gain per phase: mute/over-range (music: reversed), random, full scale.
        fx_set = '{9'd0, 9'd511, 9'($urandom_range(1, 255)), 9'd256};
        mu_set = '{9'd300, 9'd0, 9'($urandom), 9'd256};
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            write_reg(CFG_EFFECT, fx_set[ph]);
            write_reg(CFG_MUSIC, mu_set[ph]);
            for (int n = 0; n < PER_PHASE; n++)
                random_word();
        end

        drain();
        $display("sent %0d words over %0d gain settings, checked %0d frames",
                 words_sent, PHASES + 1, frames_checked);
        if (errors == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
